// ===== hw/rtl/gps_pkg.sv =====
// Package for the gravity particle step pipeline: widths, payload types,
// register indexes and the saturation helper. No dependencies.
package gps_pkg;

    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = 32;
    localparam int TAG_W     = 16;
    localparam int SRC_W     = 12;
    localparam int STR_W     = 16;
    localparam int SCALED_W  = SRC_W + FRAC_BITS;
    // offset magnitude stays below 2^33 for every source and position
    localparam int MAG_W     = DATA_W + 1;
    localparam int DIFF_W    = MAG_W + 1;
    localparam int SQ_W      = 2 * MAG_W + 1;
    localparam int ROOT_W    = (SQ_W + 1) / 2;
    localparam int L2_W      = 2 * ROOT_W;
    localparam int L3_W      = 3 * ROOT_W;
    localparam int NUM_W     = MAG_W + STR_W + 3 * FRAC_BITS;
    // quotient bits kept; anything at or above 2^Q_W saturates velocity
    localparam int Q_W       = DATA_W + 1;
    localparam int CMP_W     = L3_W + Q_W;
    localparam int ACC_W     = Q_W + 2;
    localparam int SUM_W     = ACC_W + 1;
    localparam int CUBE_LAT  = 3;
    localparam int DIV_LAT   = Q_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STR = 2'd2;

    localparam logic [SRC_W-1:0] SOURCE_X_RST   = 12'd1920;
    localparam logic [SRC_W-1:0] SOURCE_Y_RST   = 12'd1080;
    localparam logic [STR_W-1:0] SOURCE_STR_RST = 16'd7000;

    typedef struct packed {
        logic [TAG_W-1:0]         particle_tag;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } t_particle;

    typedef struct packed {
        logic [TAG_W-1:0]         tag_out;
        logic signed [DATA_W-1:0] new_pos_x;
        logic signed [DATA_W-1:0] new_pos_y;
        logic signed [DATA_W-1:0] new_vel_x;
        logic signed [DATA_W-1:0] new_vel_y;
        logic                     at_source;
        logic                     saturated;
    } t_result;

    typedef struct packed {
        t_particle        part;
        logic             neg_x;
        logic             neg_y;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
    } t_side1;

    typedef struct packed {
        t_particle part;
        logic      neg_x;
        logic      neg_y;
        logic      zero;
    } t_side2;

    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] value;
    } t_sat;

    function automatic t_sat sat_data(input logic signed [SUM_W-1:0] v);
        t_sat r;
        logic [SUM_W-DATA_W:0] hi;
        hi = v[SUM_W-1:DATA_W-1];
        r.clip  = !((hi == '0) || (hi == '1));
        if (!r.clip) begin
            r.value = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            r.value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r.value = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/gps_isqrt.sv =====
// Pipelined floor square root, one root bit per stage.
// Depends on gps_pkg for widths.
module gps_isqrt import gps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_W-1:0]   i_radicand,
    output logic [ROOT_W-1:0] o_root
);
    localparam int TRIAL_W = SQ_W + 2;

    logic [SQ_W-1:0]   r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W-1:0]    rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [TRIAL_W-1:0] trial;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_in  = i_radicand;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // trial = (2*root + 2^B) * 2^B
        assign trial = (TRIAL_W'(root_in) << (B + 1)) | (TRIAL_W'(1) << (2 * B));
        assign ge    = TRIAL_W'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= ge ? (root_in | (ROOT_W'(1) << B)) : root_in;
            end
        end

        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? SQ_W'(TRIAL_W'(rem_in) - trial) : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

// ===== hw/rtl/gps_cube.sv =====
// Cube of the distance in three stages of partial products.
// Depends on gps_pkg for widths.
module gps_cube import gps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ROOT_W-1:0] i_len,
    output logic [L3_W-1:0]   o_len3,
    output logic              o_zero
);
    logic [ROOT_W-1:0] r_len1;
    logic [L2_W-1:0]   r_len2;
    logic [L2_W-1:0]   r_plo;
    logic [L2_W-1:0]   r_phi;
    logic              r_zero2;
    logic [L3_W-1:0]   r_len3;
    logic              r_zero3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len1  <= i_len;
            r_len2  <= i_len * i_len;
            r_plo   <= r_len2[ROOT_W-1:0] * r_len1;
            r_phi   <= r_len2[L2_W-1:ROOT_W] * r_len1;
            r_zero2 <= (r_len1 == '0);
            r_len3  <= L3_W'(r_plo) + (L3_W'(r_phi) << ROOT_W);
            r_zero3 <= r_zero2;
        end
    end

    assign o_len3 = r_len3;
    assign o_zero = r_zero3;

endmodule

// ===== hw/rtl/gps_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an
// up-front overflow check. Depends on gps_pkg for widths.
module gps_divider import gps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [L3_W-1:0]  i_den,
    output logic [Q_W-1:0]   o_quot,
    output logic             o_ovf
);
    logic [NUM_W-1:0] r_rem  [Q_W];
    logic [L3_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]   r_quot [Q_W];
    logic             r_ovf  [Q_W+1];

    // quotient at or above 2^Q_W is flagged on o_ovf
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_ovf[0] <= CMP_W'(i_num) >= (CMP_W'(i_den) << Q_W);
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        localparam int I = Q_W - k;
        logic [Q_W-1:0]   q_in;
        logic [CMP_W-1:0] dsh;
        logic             ge;

        if (k == 1) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = r_quot[k-2];
        end

        assign dsh = CMP_W'(r_den[k-1]) << I;
        assign ge  = CMP_W'(r_rem[k-1]) >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quot[k-1] <= ge ? (q_in | (Q_W'(1) << I)) : q_in;
                r_ovf[k]    <= r_ovf[k-1];
            end
        end

        if (k < Q_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? NUM_W'(CMP_W'(r_rem[k-1]) - dsh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];
    assign o_ovf  = r_ovf[Q_W];

endmodule

// ===== hw/rtl/gravity_particle_step.sv =====
// Top level of the gravity particle step pipeline.
// Depends on gps_pkg, gps_isqrt, gps_cube and gps_divider.
//
//   channel    | signals                              | direction
//   -----------+--------------------------------------+----------
//   particle   | i_valid, i_particle, o_stall         | in
//   result     | o_valid, o_result, i_stall           | out
//   config     | i_cfg_we, i_cfg_idx, i_cfg_data      | in
//
// One beat enters per cycle while o_stall is low; a result passes the front,
// square root, cube, divider and back stages, one bit per root or divider stage.
// The whole pipeline advances together; it holds only while the output
// register is full and stalled, so o_stall follows i_stall in that case.
// Synchronous active-low reset clears the valid bits and loads the source defaults.
module gravity_particle_step import gps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_particle             i_particle,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_result               o_result,
    input  logic                  i_stall
);
    localparam int S1_LEN = ROOT_W + CUBE_LAT;

    logic [SRC_W-1:0] r_src_x;
    logic [SRC_W-1:0] r_src_y;
    logic [STR_W-1:0] r_str;
    logic             en;

    logic                     r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    t_particle                r_a_p, r_b_p, r_c_p;
    logic signed [DIFF_W-1:0] r_a_dx, r_a_dy;
    logic [MAG_W-1:0]         r_b_mx, r_b_my;
    logic                     r_b_nx, r_b_ny, r_c_nx, r_c_ny;
    logic [2*MAG_W-1:0]       r_c_sqx, r_c_sqy;
    logic [MAG_W+STR_W-1:0]   r_c_numx, r_c_numy;
    logic [SQ_W-1:0]          r_d_sq;
    t_side1                   r_d_side;

    logic   r_s1_vld [S1_LEN];
    t_side1 r_s1     [S1_LEN];
    logic   r_s2_vld [DIV_LAT];
    t_side2 r_s2     [DIV_LAT];

    logic [ROOT_W-1:0] root;
    logic [L3_W-1:0]   len3;
    logic              len_zero;
    logic [Q_W-1:0]    quot_x, quot_y;
    logic              ovf_x, ovf_y;

    logic                    r_f1_vld, r_f2_vld, r_f3_vld;
    t_side2                  r_f1_s;
    logic signed [ACC_W-1:0] r_f1_ax, r_f1_ay;
    t_particle               r_f2_p;
    logic                    r_f2_zero, r_f2_clip;
    logic signed [DATA_W-1:0] r_f2_vx, r_f2_vy;
    t_result                 r_out;

    logic [DIFF_W-1:0]       scaled_x, scaled_y;
    logic [ACC_W-1:0]        mag_x, mag_y;
    t_sat                    sat_vx, sat_vy, sat_px, sat_py;
    t_side1                  d_side;
    t_side2                  s2_in;

    assign en      = !(r_f3_vld && i_stall);
    assign o_stall = !en;
    assign o_valid = r_f3_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_x <= SOURCE_X_RST;
            r_src_y <= SOURCE_Y_RST;
            r_str   <= SOURCE_STR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_X:   r_src_x <= i_cfg_data[SRC_W-1:0];
                CFG_SOURCE_Y:   r_src_y <= i_cfg_data[SRC_W-1:0];
                CFG_SOURCE_STR: r_str   <= i_cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_c_vld  <= 1'b0;
            r_d_vld  <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            for (int j = 0; j < S1_LEN; j++) r_s1_vld[j] <= 1'b0;
            for (int j = 0; j < DIV_LAT; j++) r_s2_vld[j] <= 1'b0;
        end else if (en) begin
            r_a_vld     <= i_valid;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            r_d_vld     <= r_c_vld;
            r_s1_vld[0] <= r_d_vld;
            for (int j = 1; j < S1_LEN; j++) r_s1_vld[j] <= r_s1_vld[j-1];
            r_s2_vld[0] <= r_s1_vld[S1_LEN-1];
            for (int j = 1; j < DIV_LAT; j++) r_s2_vld[j] <= r_s2_vld[j-1];
            r_f1_vld    <= r_s2_vld[DIV_LAT-1];
            r_f2_vld    <= r_f1_vld;
            r_f3_vld    <= r_f2_vld;
        end
    end

    assign scaled_x = DIFF_W'({r_src_x, {FRAC_BITS{1'b0}}});
    assign scaled_y = DIFF_W'({r_src_y, {FRAC_BITS{1'b0}}});

    always_comb begin
        d_side.part  = r_c_p;
        d_side.neg_x = r_c_nx;
        d_side.neg_y = r_c_ny;
        d_side.num_x = NUM_W'(r_c_numx) << (3 * FRAC_BITS);
        d_side.num_y = NUM_W'(r_c_numy) << (3 * FRAC_BITS);
    end

    // front: offset, magnitude, squares, sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_p    <= i_particle;
            r_a_dx   <= $signed(scaled_x) - DIFF_W'(i_particle.pos_x);
            r_a_dy   <= $signed(scaled_y) - DIFF_W'(i_particle.pos_y);
            r_b_p    <= r_a_p;
            r_b_nx   <= r_a_dx[DIFF_W-1];
            r_b_ny   <= r_a_dy[DIFF_W-1];
            r_b_mx   <= MAG_W'(r_a_dx[DIFF_W-1] ? -r_a_dx : r_a_dx);
            r_b_my   <= MAG_W'(r_a_dy[DIFF_W-1] ? -r_a_dy : r_a_dy);
            r_c_p    <= r_b_p;
            r_c_nx   <= r_b_nx;
            r_c_ny   <= r_b_ny;
            r_c_sqx  <= r_b_mx * r_b_mx;
            r_c_sqy  <= r_b_my * r_b_my;
            r_c_numx <= r_b_mx * r_str;
            r_c_numy <= r_b_my * r_str;
            r_d_sq   <= SQ_W'(r_c_sqx) + SQ_W'(r_c_sqy);
            r_d_side <= d_side;
        end
    end

    gps_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_radicand (r_d_sq),
        .o_root     (root)
    );

    gps_cube u_cube (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_len  (root),
        .o_len3 (len3),
        .o_zero (len_zero)
    );

    // hold the item's side data alongside the root and cube
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= r_d_side;
            for (int j = 1; j < S1_LEN; j++) r_s1[j] <= r_s1[j-1];
        end
    end

    gps_divider u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_s1[S1_LEN-1].num_x),
        .i_den  (len3),
        .o_quot (quot_x),
        .o_ovf  (ovf_x)
    );

    gps_divider u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_s1[S1_LEN-1].num_y),
        .i_den  (len3),
        .o_quot (quot_y),
        .o_ovf  (ovf_y)
    );

    always_comb begin
        s2_in.part  = r_s1[S1_LEN-1].part;
        s2_in.neg_x = r_s1[S1_LEN-1].neg_x;
        s2_in.neg_y = r_s1[S1_LEN-1].neg_y;
        s2_in.zero  = len_zero;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2[0] <= s2_in;
            for (int j = 1; j < DIV_LAT; j++) r_s2[j] <= r_s2[j-1];
        end
    end

    // back: signed acceleration, velocity, position
    always_comb begin
        if (r_s2[DIV_LAT-1].zero) begin
            mag_x = '0;
            mag_y = '0;
        end else begin
            mag_x = ovf_x ? (ACC_W'(1) << Q_W) : ACC_W'(quot_x);
            mag_y = ovf_y ? (ACC_W'(1) << Q_W) : ACC_W'(quot_y);
        end
    end

    assign sat_vx = sat_data(SUM_W'(r_f1_s.part.vel_x) + SUM_W'(r_f1_ax));
    assign sat_vy = sat_data(SUM_W'(r_f1_s.part.vel_y) + SUM_W'(r_f1_ay));
    assign sat_px = sat_data(SUM_W'(r_f2_p.pos_x) + SUM_W'(r_f2_vx));
    assign sat_py = sat_data(SUM_W'(r_f2_p.pos_y) + SUM_W'(r_f2_vy));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_s  <= r_s2[DIV_LAT-1];
            r_f1_ax <= r_s2[DIV_LAT-1].neg_x ? -$signed(mag_x) : $signed(mag_x);
            r_f1_ay <= r_s2[DIV_LAT-1].neg_y ? -$signed(mag_y) : $signed(mag_y);

            r_f2_p    <= r_f1_s.part;
            r_f2_zero <= r_f1_s.zero;
            r_f2_vx   <= sat_vx.value;
            r_f2_vy   <= sat_vy.value;
            r_f2_clip <= sat_vx.clip | sat_vy.clip;

            r_out.tag_out   <= r_f2_p.particle_tag;
            r_out.new_pos_x <= sat_px.value;
            r_out.new_pos_y <= sat_py.value;
            r_out.new_vel_x <= r_f2_vx;
            r_out.new_vel_y <= r_f2_vy;
            r_out.at_source <= r_f2_zero;
            r_out.saturated <= r_f2_clip | sat_px.clip | sat_py.clip;
        end
    end

endmodule

// ===== hw/rtl/gps_checker.sv =====
// Port-level checks for gravity_particle_step, bound to the top level.
// Depends on gps_pkg for the payload types.
module gps_checker import gps_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input t_particle             i_particle,
    input logic                  o_stall,
    input logic                  o_valid,
    input t_result               o_result,
    input logic                  i_stall
);
    // intake holds only behind a full, stalled output
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("o_stall not tied to stalled output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled input beat is held until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_particle))
        else $error("stalled input beat changed");

endmodule

bind gravity_particle_step gps_checker u_gps_checker (.*);
